FILE: hw/rtl/rpa_pkg.sv
`default_nettype none

package rpa_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_PAGES  = 16384;
    localparam int DEF_COUNT_BITS = 8;

    // Fixed field widths
    localparam int PAGE_W   = 14;
    localparam int LIMIT_W  = 15;
    localparam int CFG_W    = 15;
    localparam int REF_W    = 8;
    localparam int FREE_W   = 15;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DROP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SEED  = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    // Input item
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PAGE_W-1:0] page;
    } t_req;

    // Result item
    typedef struct packed {
        logic [PAGE_W-1:0]   result_page;
        logic [STATUS_W-1:0] status;
        logic [REF_W-1:0]    ref_value;
        logic [FREE_W-1:0]   free_pages;
    } t_rsp;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_SEED,
        OP_ADD,
        OP_DROP,
        OP_READ,
        OP_RANGE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [PAGE_W-1:0] page;
    } t_cmd;

endpackage

`default_nettype wire

FILE: hw/rtl/refcounted_page_allocator.sv
`default_nettype none

// Reference-counted page allocator. Keeps a last-in first-out stack of free
// page numbers and a reference count for each of NUM_PAGES pages. Each input
// transfer carries a mode (alloc, free, add ref, drop ref, read, seed) and a
// page; each yields exactly one result transfer with the granted or echoed
// page, a status, the page's count afterwards and the number of free pages.
// After reset the block sweeps the count memory to zero, one entry a cycle,
// and input ready stays low for the whole pass; configuration writes are
// taken during that pass. Afterward the back end first reads the count and
// stack memories for an item, then updates them and loads the result
// register, waiting there while an earlier result is not yet taken. It
// takes no new item until the current one is done. A two-entry queue sits
// between the front end, which checks the page range, and the back end; the
// result register lets the next item be taken and read while a result waits.
// Write first_page and page_limit only while the block is idle.
module refcounted_page_allocator #(
    parameter int NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
    parameter int COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  rpa_pkg::t_req               i_in,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output rpa_pkg::t_rsp               o_out,
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_idx,
    input  wire  [rpa_pkg::CFG_W-1:0]   i_cfg_data
);
    import rpa_pkg::*;

    logic [PAGE_W-1:0]  r_first_page;
    logic [LIMIT_W-1:0] r_page_limit;

    logic clearing;
    logic fq_valid, fq_ready;
    t_cmd fq_cmd;
    logic qb_valid, qb_ready;
    t_cmd qb_cmd;

    // Configuration registers: plain writes, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= '0;
            r_page_limit <= LIMIT_W'(16384);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_PAGE: r_first_page <= i_cfg_data[PAGE_W-1:0];
                CFG_PAGE_LIMIT: r_page_limit <= i_cfg_data[LIMIT_W-1:0];
                default:        r_first_page <= r_first_page;
            endcase
        end
    end

    // Front: accept the transfer and classify it
    rpa_front #(
        .NUM_PAGES (NUM_PAGES)
    ) u_front (
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_req        (i_in),
        .i_first_page (r_first_page),
        .i_page_limit (r_page_limit),
        .i_clearing   (clearing),
        .o_q_valid    (fq_valid),
        .i_q_ready    (fq_ready),
        .o_q_cmd      (fq_cmd)
    );

    // Queue: decouple front from back
    rpa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_cmd   (fq_cmd),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_cmd    (qb_cmd)
    );

    // Back: memories, stack pointer and result register
    rpa_back #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (qb_valid),
        .o_q_ready   (qb_ready),
        .i_q_cmd     (qb_cmd),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rpa_front.sv
`default_nettype none

module rpa_front #(
    parameter int NUM_PAGES = rpa_pkg::DEF_NUM_PAGES
) (
    input  wire                           i_valid,
    output logic                          o_ready,
    input  rpa_pkg::t_req                 i_req,
    input  wire  [rpa_pkg::PAGE_W-1:0]    i_first_page,
    input  wire  [rpa_pkg::LIMIT_W-1:0]   i_page_limit,
    input  wire                           i_clearing,
    output logic                          o_q_valid,
    input  wire                           i_q_ready,
    output rpa_pkg::t_cmd                 o_q_cmd
);
    import rpa_pkg::*;

    logic in_range;

    // Range test against the configured window and the memory size
    assign in_range = (i_req.page >= i_first_page)
                   && ({1'b0, i_req.page} < i_page_limit)
                   && (32'(i_req.page) < NUM_PAGES);

    always_comb begin
        o_q_cmd.page = i_req.page;
        if (i_req.mode == MODE_ALLOC) begin
            o_q_cmd.op = OP_ALLOC;
        end else if (!in_range) begin
            o_q_cmd.op = OP_RANGE;
        end else begin
            unique case (i_req.mode)
                MODE_FREE: o_q_cmd.op = OP_FREE;
                MODE_SEED: o_q_cmd.op = OP_SEED;
                MODE_ADD:  o_q_cmd.op = OP_ADD;
                MODE_DROP: o_q_cmd.op = OP_DROP;
                default:   o_q_cmd.op = OP_READ;
            endcase
        end
    end

    // Hold off items while the count memory is being cleared
    assign o_ready   = i_q_ready && !i_clearing;
    assign o_q_valid = i_valid && !i_clearing;

endmodule

`default_nettype wire

FILE: hw/rtl/rpa_queue.sv
`default_nettype none

module rpa_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push_valid,
    output logic           o_push_ready,
    input  rpa_pkg::t_cmd  i_push_cmd,
    output logic           o_pop_valid,
    input  wire            i_pop_ready,
    output rpa_pkg::t_cmd  o_pop_cmd
);
    import rpa_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           push, pop;

    assign o_push_ready = (r_count != QCW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue empty with pointers apart");

endmodule

`default_nettype wire

FILE: hw/rtl/rpa_back.sv
`default_nettype none

module rpa_back #(
    parameter int NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
    parameter int COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_q_valid,
    output logic           o_q_ready,
    input  rpa_pkg::t_cmd  i_q_cmd,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output rpa_pkg::t_rsp  o_out
);
    import rpa_pkg::*;

    localparam int AW = $clog2(NUM_PAGES);
    localparam int DW = $clog2(NUM_PAGES + 1);
    localparam int CB = COUNT_BITS;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    logic [CB-1:0]     mem_cnt [NUM_PAGES];
    logic [PAGE_W-1:0] mem_stk [NUM_PAGES];

    t_state            r_state;
    logic [AW-1:0]     r_clr_addr;
    logic [DW-1:0]     r_depth;
    t_cmd              r_cmd;
    logic [CB-1:0]     r_cnt_q;
    logic [PAGE_W-1:0] r_stk_q;
    logic              r_out_valid;
    t_rsp              r_out;

    logic              take, fire;
    logic              cnt_we, stk_we;
    logic [AW-1:0]     cnt_waddr;
    logic [CB-1:0]     cnt_wdata;
    logic [CB-1:0]     c_base, c_dec, c_new;
    logic [DW-1:0]     n_depth;
    t_rsp              n_out;

    assign take        = (r_state == S_IDLE) && i_q_valid;
    assign fire        = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_q_ready   = (r_state == S_IDLE);
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Memory reads: registered, issued while taking an item
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cnt_q <= mem_cnt[AW'(i_q_cmd.page)];
            r_stk_q <= mem_stk[AW'(r_depth - 1'b1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[cnt_waddr] <= cnt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[AW'(r_depth)] <= r_cmd.page;
        end
    end

    assign c_base = (r_cmd.op == OP_SEED) ? '0 : r_cnt_q;
    assign c_dec  = (c_base != '0) ? c_base - 1'b1 : '0;

    always_comb begin
        cnt_we            = 1'b0;
        cnt_waddr         = AW'(r_cmd.page);
        cnt_wdata         = '0;
        stk_we            = 1'b0;
        c_new             = r_cnt_q;
        n_depth           = r_depth;
        n_out.result_page = r_cmd.page;
        n_out.status      = STATUS_OK;
        n_out.ref_value   = '0;

        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr_addr;
        end else begin
            unique case (r_cmd.op)
                OP_ALLOC: begin
                    if (r_depth == '0) begin
                        n_out.status      = STATUS_NOFREE;
                        n_out.result_page = '0;
                    end else begin
                        n_depth           = r_depth - 1'b1;
                        n_out.result_page = r_stk_q;
                        n_out.ref_value   = REF_W'(1);
                        cnt_we            = fire && (32'(r_stk_q) < NUM_PAGES);
                        cnt_waddr         = AW'(r_stk_q);
                        cnt_wdata         = {{(CB-1){1'b0}}, 1'b1};
                    end
                end
                OP_RANGE: begin
                    n_out.status = STATUS_RANGE;
                end
                default: begin
                    unique case (r_cmd.op)
                        OP_FREE, OP_SEED: c_new = c_dec;
                        OP_ADD:           c_new = (&r_cnt_q) ? r_cnt_q : r_cnt_q + 1'b1;
                        OP_DROP:          c_new = (r_cnt_q != '0) ? r_cnt_q - 1'b1 : '0;
                        default:          c_new = r_cnt_q;
                    endcase
                    // Push the page once a free or seed leaves it unreferenced
                    if ((r_cmd.op == OP_FREE || r_cmd.op == OP_SEED) && c_new == '0) begin
                        if (r_depth < DW'(NUM_PAGES)) begin
                            stk_we  = fire;
                            n_depth = r_depth + 1'b1;
                        end else begin
                            n_out.status = STATUS_FULL;
                        end
                    end
                    cnt_we          = fire;
                    cnt_wdata       = c_new;
                    n_out.ref_value = REF_W'(c_new);
                end
            endcase
        end
        n_out.free_pages = FREE_W'(n_depth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(NUM_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        r_depth <= n_depth;
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(NUM_PAGES))
        else $error("free stack depth above page count");

    a_depth_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != $past(r_depth)) |->
            (r_depth == $past(r_depth) + 1'b1 || r_depth == $past(r_depth) - 1'b1))
        else $error("free stack depth jumped");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC))
        else $error("result loaded outside execute");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !$past(take))
        else $error("item taken during clearing pass");

endmodule

`default_nettype wire
